/* hw/rtl/assert_macros.svh */
// Assertion helpers used by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/oea_pkg.sv */
`timescale 1ns / 1ps

package oea_pkg;

	// Addressing modes
	localparam logic [1:0] MODE_IMM = 2'd0;
	localparam logic [1:0] MODE_DIR = 2'd1;
	localparam logic [1:0] MODE_EXT = 2'd2;
	localparam logic [1:0] MODE_IDX = 2'd3;

	// Base register select, postbyte bits 6..5
	localparam logic [1:0] BASE_X = 2'd0;
	localparam logic [1:0] BASE_Y = 2'd1;
	localparam logic [1:0] BASE_U = 2'd2;
	localparam logic [1:0] BASE_S = 2'd3;

	// Offset kind, postbyte low nibble when bit 7 is set
	localparam logic [3:0] NIB_ZERO = 4'h4;
	localparam logic [3:0] NIB_B    = 4'h5;
	localparam logic [3:0] NIB_A    = 4'h6;
	localparam logic [3:0] NIB_OFF8 = 4'h8;
	localparam logic [3:0] NIB_OFF16 = 4'h9;
	localparam logic [3:0] NIB_D    = 4'hB;

	// Extended indirect postbyte
	localparam logic [7:0] PB_EXT_IND = 8'h9F;

	// Cycle costs
	localparam logic [2:0] CYC_IND     = 3'd3;
	localparam logic [2:0] CYC_EXT_IND = 3'd5;

	typedef struct packed {
		logic [1:0]  req_type;
		logic        operand_is_word;
		logic [15:0] pc;
		logic [7:0]  direct_page;
		logic [7:0]  operand_byte0;
		logic [7:0]  operand_byte1;
		logic [7:0]  operand_byte2;
		logic [15:0] index_x;
		logic [15:0] index_y;
		logic [15:0] user_sp;
		logic [15:0] system_sp;
		logic [15:0] acc_d;
	} oea_req_t;

	typedef struct packed {
		logic [15:0] eff_address;
		logic        indirect;
		logic [15:0] next_pc;
		logic [2:0]  extra_cycles;
		logic        unsupported;
	} oea_rsp_t;

endpackage

/* hw/rtl/oea_decode.sv */
`timescale 1ns / 1ps

module oea_decode (
	input  oea_pkg::oea_req_t req,
	output oea_pkg::oea_rsp_t rsp
);
	import oea_pkg::*;

	logic [15:0] base;
	logic [15:0] offset;
	logic [2:0]  cyc;
	logic        ok;
	logic [15:0] pc_p1;

	assign pc_p1 = req.pc + 16'd1;

	// Pick the index base register
	always_comb begin
		case (req.operand_byte0[6:5])
			BASE_X:  base = req.index_x;
			BASE_Y:  base = req.index_y;
			BASE_U:  base = req.user_sp;
			BASE_S:  base = req.system_sp;
			default: base = req.index_x;
		endcase
	end

	// Decode the indexed offset and its cost
	always_comb begin
		offset = 16'd0;
		cyc    = 3'd0;
		ok     = 1'b1;
		case (req.operand_byte0[3:0])
			NIB_ZERO: begin
				offset = 16'd0;
				cyc    = 3'd0;
			end
			NIB_OFF8: begin
				offset = {{8{req.operand_byte1[7]}}, req.operand_byte1};
				cyc    = 3'd1;
			end
			NIB_OFF16: begin
				offset = {req.operand_byte1, req.operand_byte2};
				cyc    = 3'd4;
			end
			NIB_A: begin
				offset = {{8{req.acc_d[15]}}, req.acc_d[15:8]};
				cyc    = 3'd1;
			end
			NIB_B: begin
				offset = {{8{req.acc_d[7]}}, req.acc_d[7:0]};
				cyc    = 3'd1;
			end
			NIB_D: begin
				offset = req.acc_d;
				cyc    = 3'd4;
			end
			default: ok = 1'b0;
		endcase
	end

	// Form the result for each addressing mode
	always_comb begin
		rsp = '0;
		rsp.next_pc = req.pc;
		case (req.req_type)
			MODE_IMM: begin
				rsp.eff_address = req.pc;
				rsp.next_pc     = pc_p1 + {15'd0, req.operand_is_word};
			end
			MODE_DIR: begin
				rsp.eff_address = {req.direct_page, req.operand_byte0};
				rsp.next_pc     = pc_p1;
			end
			MODE_EXT: begin
				rsp.eff_address = {req.operand_byte0, req.operand_byte1};
				rsp.next_pc     = req.pc + 16'd2;
			end
			MODE_IDX: begin
				if (!req.operand_byte0[7]) begin
					// Five-bit signed constant offset
					rsp.eff_address = base + {{11{req.operand_byte0[4]}},
						req.operand_byte0[4:0]};
					rsp.extra_cycles = 3'd1;
					rsp.next_pc      = pc_p1;
				end else if (req.operand_byte0 == PB_EXT_IND) begin
					rsp.unsupported  = 1'b1;
					rsp.extra_cycles = CYC_EXT_IND;
				end else if (ok) begin
					rsp.eff_address  = base + offset;
					rsp.indirect     = req.operand_byte0[4];
					rsp.extra_cycles = req.operand_byte0[4] ? cyc + CYC_IND : cyc;
					case (req.operand_byte0[3:0])
						NIB_OFF8:  rsp.next_pc = req.pc + 16'd2;
						NIB_OFF16: rsp.next_pc = req.pc + 16'd3;
						default:   rsp.next_pc = pc_p1;
					endcase
				end else begin
					// Auto increment/decrement, PC relative and undefined forms
					rsp.unsupported = 1'b1;
				end
			end
			default: rsp = '0;
		endcase
	end

endmodule

/* hw/rtl/operand_effective_address.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Operand effective address unit: one instruction's addressing request in, one
// result (address, indirect flag, next PC, extra cycles, unsupported flag) out.
// A transaction is registered on entry, decoded by a single combinational pass
// and registered again on exit; its result is presented from the result
// register. A new request can be taken every cycle while results drain.
// While a finished result waits for the consumer, one more request is taken into
// the input register; after that the request side stalls until the result leaves.
// Indexed indirect forms return the pointer location with indirect set; the pointer
// itself is not fetched, and extended indirect is reported as unsupported.

module operand_effective_address (
	input  logic        clk,
	input  logic        arst_n,
	// Request channel
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  req_type,
	input  logic        operand_is_word,
	input  logic [15:0] pc,
	input  logic [7:0]  direct_page,
	input  logic [7:0]  operand_byte0,
	input  logic [7:0]  operand_byte1,
	input  logic [7:0]  operand_byte2,
	input  logic [15:0] index_x,
	input  logic [15:0] index_y,
	input  logic [15:0] user_sp,
	input  logic [15:0] system_sp,
	input  logic [15:0] acc_d,
	// Result channel
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [15:0] eff_address,
	output logic        indirect,
	output logic [15:0] next_pc,
	output logic [2:0]  extra_cycles,
	output logic        unsupported
);
	import oea_pkg::*;

	oea_req_t req_in;
	oea_req_t req_s1;
	oea_rsp_t rsp_dec;
	oea_rsp_t rsp_s2;
	logic     valid_s1;
	logic     valid_s2;
	logic     adv_s1;
	logic     load_s1;

	// Gather the request fields
	assign req_in = '{
		req_type:        req_type,
		operand_is_word: operand_is_word,
		pc:              pc,
		direct_page:     direct_page,
		operand_byte0:   operand_byte0,
		operand_byte1:   operand_byte1,
		operand_byte2:   operand_byte2,
		index_x:         index_x,
		index_y:         index_y,
		user_sp:         user_sp,
		system_sp:       system_sp,
		acc_d:           acc_d
	};

	// Advance when the output register is free or being drained
	assign adv_s1    = !valid_s2 || rsp_ready;
	assign req_ready = !valid_s1 || adv_s1;
	assign load_s1   = req_valid && req_ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			req_s1 <= req_in;
		end
	end

	oea_decode u_decode (
		.req (req_s1),
		.rsp (rsp_dec)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			rsp_s2 <= rsp_dec;
		end
	end

	assign rsp_valid    = valid_s2;
	assign eff_address  = rsp_s2.eff_address;
	assign indirect     = rsp_s2.indirect;
	assign next_pc      = rsp_s2.next_pc;
	assign extra_cycles = rsp_s2.extra_cycles;
	assign unsupported  = rsp_s2.unsupported;

	// Assertions
	`ASSERT_CLK(a_unsup_zero, clk, arst_n, rsp_valid && unsupported |-> eff_address == 16'd0 && !indirect, "unsupported result with nonzero address or indirect set")
	`ASSERT_CLK(a_ind_cost, clk, arst_n, rsp_valid && indirect |-> extra_cycles >= CYC_IND && !unsupported, "indirect result without indirection cost")
	`ASSERT_CLK(a_s1_moves, clk, arst_n, valid_s1 && adv_s1 |=> valid_s2, "decoded transaction dropped between stages")
	`ASSERT_CLK_ALWAYS(a_stall_full, clk, !req_ready |-> valid_s1 && valid_s2 && !rsp_ready, "request stalled while pipeline has room")

endmodule
